[hw/rtl/signal_activity_ring_log_assert.svh]
// Assertion macros shared by the signal activity ring log RTL.
`ifndef SIGNAL_ACTIVITY_RING_LOG_ASSERT_SVH
`define SIGNAL_ACTIVITY_RING_LOG_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SARL_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define SARL_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sarl_pkg.sv]
// Package with widths, codes, entry layout and control structs of the ring log.
`default_nettype none

package sarl_pkg;

	localparam int unsigned LOG_DEPTH_DEF = 32;

	localparam int unsigned MODE_W     = 3;
	localparam int unsigned FREQ_W     = 28;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned RSSI_W     = 9;
	localparam int unsigned TONE_W     = 12;
	localparam int unsigned QUAL_W     = 8;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CFG_ADDR_W = 1;

	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned S_TUSER_W = MODE_W;
	localparam int unsigned M_TDATA_W = 112;
	localparam int unsigned M_TUSER_W = 2;

	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;

	localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_WINDOW = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIME_WINDOW = 1'b1;

	localparam logic [CFG_W-1:0]  FREQ_WINDOW_RST = 16'd1000;
	localparam logic [CFG_W-1:0]  TIME_WINDOW_RST = 16'd10;
	localparam logic [TIME_W-1:0] UPTIME_MAX      = 16'hFFFF;
	localparam logic [IDX_W-1:0]  POS_MISS        = 8'hFF;

	// One stored log entry, as it sits in the RAM word.
	typedef struct packed {
		logic [FREQ_W-1:0]        freq;
		logic [TIME_W-1:0]        start;
		logic [TIME_W-1:0]        dur;
		logic signed [RSSI_W-1:0] rssi;
		logic [TONE_W-1:0]        tone;
		logic [QUAL_W-1:0]        qual;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic res_init;
		logic add_commit;
		logic rd_newest;
		logic rd_index;
		logic find_start;
		logic find_step;
		logic take_entry;
		logic tick;
		logic clear;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              cnt_zero;
		logic              ridx_ok;
		logic              match;
		logic              find_last;
	} stat_t;

endpackage

`default_nettype wire

[hw/rtl/sarl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sarl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/sarl_dp.sv]
// Datapath of the ring log: item registers, log RAM, pointers, compares and result registers.
`default_nettype none

module sarl_dp #(
	parameter int unsigned LOG_DEPTH = sarl_pkg::LOG_DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [sarl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [sarl_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire logic [sarl_pkg::S_TDATA_W-1:0]      s_tdata,
	input  wire logic [sarl_pkg::S_TUSER_W-1:0]      s_tuser,
	input  wire sarl_pkg::cmd_t                      cmd,
	output sarl_pkg::stat_t                          stat,
	output logic      [sarl_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic      [sarl_pkg::M_TUSER_W-1:0]      m_tuser
);

	import sarl_pkg::*;

	localparam int unsigned AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int unsigned SW = IDX_W + 2;
	localparam logic [AW-1:0]    LAST_SLOT = AW'(LOG_DEPTH - 1);
	localparam logic [SW-1:0]    DEPTH_S   = SW'(LOG_DEPTH);
	localparam logic [IDX_W-1:0] DEPTH_C   = IDX_W'(LOG_DEPTH);
	localparam int unsigned      PAD_W     = M_TDATA_W - IDX_W - $bits(entry_t) - IDX_W;

	// Accepted item.
	logic [MODE_W-1:0]        mode_q;
	logic [FREQ_W-1:0]        freq_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic [TONE_W-1:0]        tone_q;
	logic [QUAL_W-1:0]        qual_q;
	logic [IDX_W-1:0]         ridx_q;

	// Log control state and configuration.
	logic [AW-1:0]    wp_q;
	logic [IDX_W-1:0] cnt_q;
	logic [TIME_W-1:0] uptime_q;
	logic [CFG_W-1:0] fwin_q;
	logic [CFG_W-1:0] twin_q;

	// Find walk.
	logic [AW-1:0]    slot_q;
	logic [IDX_W-1:0] pos_q;

	// Result being built and output register.
	logic             res_found_q;
	logic             res_merged_q;
	logic [IDX_W-1:0] res_pos_q;
	entry_t           res_entry_q;
	logic             out_found_q;
	logic             out_merged_q;
	logic [IDX_W-1:0] out_pos_q;
	entry_t           out_entry_q;
	logic [IDX_W-1:0] out_cnt_q;

	logic [AW-1:0]     newest;
	logic [AW-1:0]     newest_prev;
	logic [AW-1:0]     slot_prev;
	logic [SW-1:0]     idx_sum;
	logic [AW-1:0]     idx_slot;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	entry_t            rd_entry;
	logic [FREQ_W-1:0] fdiff;
	logic              freq_near;
	logic [TIME_W-1:0] age;
	logic              merge_ok;
	logic              do_merge;
	entry_t            merged_entry;
	entry_t            new_entry;
	logic [AW-1:0]     wr_addr;
	entry_t            wr_entry;

	always_comb begin
		newest      = (wp_q == '0) ? LAST_SLOT : wp_q - 1'b1;
		newest_prev = (newest == '0) ? LAST_SLOT : newest - 1'b1;
		slot_prev   = (slot_q == '0) ? LAST_SLOT : slot_q - 1'b1;
		// Slot of a recency position: newest slot minus position, modulo the depth.
		idx_sum     = SW'(wp_q) + DEPTH_S - SW'(1) - SW'(ridx_q);
		idx_slot    = (idx_sum >= DEPTH_S) ? AW'(idx_sum - DEPTH_S) : AW'(idx_sum);
	end

	always_comb begin
		rd_en = cmd.rd_newest | cmd.rd_index | cmd.find_start | cmd.find_step;
		priority if (cmd.rd_index) begin
			rd_addr = idx_slot;
		end else if (cmd.find_step) begin
			rd_addr = slot_q;
		end else begin
			rd_addr = newest;
		end
	end

	always_comb begin
		fdiff     = (freq_q >= rd_entry.freq) ? freq_q - rd_entry.freq : rd_entry.freq - freq_q;
		freq_near = fdiff <= FREQ_W'(fwin_q);
		age       = uptime_q - rd_entry.start;
		merge_ok  = freq_near && (age <= twin_q);
		do_merge  = cmd.add_commit && (cnt_q != '0) && merge_ok;

		merged_entry      = rd_entry;
		merged_entry.dur  = age;
		if (rssi_q > rd_entry.rssi) begin
			merged_entry.rssi = rssi_q;
		end
		if (tone_q != '0) begin
			merged_entry.tone = tone_q;
		end
		if (qual_q > rd_entry.qual) begin
			merged_entry.qual = qual_q;
		end

		new_entry.freq  = freq_q;
		new_entry.start = uptime_q;
		new_entry.dur   = '0;
		new_entry.rssi  = rssi_q;
		new_entry.tone  = tone_q;
		new_entry.qual  = qual_q;

		wr_addr  = do_merge ? newest : wp_q;
		wr_entry = do_merge ? merged_entry : new_entry;
	end

	sarl_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(LOG_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.add_commit),
		.waddr(wr_addr),
		.wdata(wr_entry),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			cnt_q    <= '0;
			uptime_q <= '0;
			fwin_q   <= FREQ_WINDOW_RST;
			twin_q   <= TIME_WINDOW_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_FREQ_WINDOW: fwin_q <= cfg_wdata;
					CFG_TIME_WINDOW: twin_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.tick && (uptime_q != UPTIME_MAX)) begin
				uptime_q <= uptime_q + 1'b1;
			end
			if (cmd.clear) begin
				wp_q  <= '0;
				cnt_q <= '0;
			end else if (cmd.add_commit && !do_merge) begin
				wp_q <= (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
				if (cnt_q < DEPTH_C) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q <= s_tuser;
			freq_q <= s_tdata[27:0];
			rssi_q <= s_tdata[36:28];
			tone_q <= s_tdata[48:37];
			qual_q <= s_tdata[56:49];
			ridx_q <= s_tdata[64:57];
		end
		if (cmd.find_start) begin
			slot_q <= newest_prev;
			pos_q  <= '0;
		end else if (cmd.find_step) begin
			slot_q <= slot_prev;
			pos_q  <= pos_q + 1'b1;
		end
		if (cmd.res_init) begin
			res_found_q  <= 1'b0;
			res_entry_q  <= '0;
			res_pos_q    <= (mode_q == MODE_FIND) ? POS_MISS : '0;
		end
		// An add into an empty log commits in the same cycle as the result is initialized.
		if (cmd.res_init || cmd.add_commit) begin
			res_merged_q <= cmd.add_commit && do_merge;
		end
		if (cmd.take_entry) begin
			res_found_q <= 1'b1;
			res_entry_q <= rd_entry;
			res_pos_q   <= (mode_q == MODE_FIND) ? pos_q : '0;
		end
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_merged_q <= res_merged_q;
			out_pos_q    <= res_pos_q;
			out_entry_q  <= res_entry_q;
			out_cnt_q    <= cnt_q;
		end
	end

	always_comb begin
		stat.mode      = mode_q;
		stat.cnt_zero  = (cnt_q == '0);
		stat.ridx_ok   = (ridx_q < cnt_q);
		stat.match     = freq_near;
		stat.find_last = ((IDX_W + 1)'(pos_q) + 1'b1) == (IDX_W + 1)'(cnt_q);
	end

	assign m_tdata = {PAD_W'(0), out_cnt_q, out_entry_q.qual, out_entry_q.tone,
		out_entry_q.rssi, out_entry_q.dur, out_entry_q.start, out_entry_q.freq, out_pos_q};
	assign m_tuser = {out_merged_q, out_found_q};

endmodule

`default_nettype wire

[hw/rtl/sarl_ctrl.sv]
// Controller state machine of the ring log: sequences each item and owns the handshakes.
`default_nettype none

module sarl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	input  wire sarl_pkg::stat_t stat,
	output sarl_pkg::cmd_t       cmd
);

	import sarl_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DECODE  = 3'd1;
	localparam logic [2:0] ST_ADD_CHK = 3'd2;
	localparam logic [2:0] ST_RD_WAIT = 3'd3;
	localparam logic [2:0] ST_FIND    = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.res_init = 1'b1;
				state_d      = ST_DONE;
				unique case (stat.mode)
					MODE_ADD: begin
						if (stat.cnt_zero) begin
							cmd.add_commit = 1'b1;
						end else begin
							cmd.rd_newest = 1'b1;
							state_d       = ST_ADD_CHK;
						end
					end
					MODE_TICK:  cmd.tick = 1'b1;
					MODE_CLEAR: cmd.clear = 1'b1;
					MODE_READ: begin
						if (stat.ridx_ok) begin
							cmd.rd_index = 1'b1;
							state_d      = ST_RD_WAIT;
						end
					end
					MODE_FIND: begin
						if (!stat.cnt_zero) begin
							cmd.find_start = 1'b1;
							state_d        = ST_FIND;
						end
					end
					default: ;
				endcase
			end
			ST_ADD_CHK: begin
				cmd.add_commit = 1'b1;
				state_d        = ST_DONE;
			end
			ST_RD_WAIT: begin
				cmd.take_entry = 1'b1;
				state_d        = ST_DONE;
			end
			ST_FIND: begin
				priority if (stat.match) begin
					cmd.take_entry = 1'b1;
					state_d        = ST_DONE;
				end else if (stat.find_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.find_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/signal_activity_ring_log.sv]
// Each item passes decode and then the done state; tick, clear, read miss, add to an empty log,
// find on an empty log and unused codes take no other state, while read hit and add to a
// nonempty log pass one more state; find compares up to LOG_DEPTH entries, one per RAM read.
// One item at a time; the next is accepted the cycle after a result is handed to the output
// register. Reset clears pointer, count, uptime, handshakes and sets the windows to 1000 and 10.
`default_nettype none
`include "signal_activity_ring_log_assert.svh"

module signal_activity_ring_log #(
	parameter int unsigned LOG_DEPTH = sarl_pkg::LOG_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Configuration: index 0 is freq_window, index 1 is time_window.
	input  wire logic                            cfg_we,
	input  wire logic [sarl_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [sarl_pkg::CFG_W-1:0]      cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// freq[27:0], rssi[36:28], tone[48:37], quality[56:49], recency_index[64:57], zero pad.
	input  wire logic [sarl_pkg::S_TDATA_W-1:0]  s_tdata,
	// mode[2:0].
	input  wire logic [sarl_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// found_position[7:0], entry_freq[35:8], entry_time[51:36], entry_duration[67:52],
	// entry_rssi[76:68], entry_tone[88:77], entry_quality[96:89], entry_count[104:97], zero pad.
	output logic      [sarl_pkg::M_TDATA_W-1:0]  m_tdata,
	// found[0], merged[1].
	output logic      [sarl_pkg::M_TUSER_W-1:0]  m_tuser
);

	import sarl_pkg::*;

	// The controller walks each item through a short state sequence and drives the datapath
	// with one command word per cycle; the datapath reports back mode, count and compares.
	cmd_t  cmd;
	stat_t stat;

	// The controller owns both handshakes. An item is taken only in its idle state, and the
	// finished result sits in the datapath's output register, so a new item can be accepted
	// while the previous result still waits for the sink.
	sarl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// The datapath holds the log RAM (one word per entry, registered read), the write pointer,
	// the fill count, the uptime counter, the two window registers and the result registers.
	// An add reads the newest entry, decides on a merge in the cycle its data returns, and
	// writes either the merged entry back or a fresh one at the write pointer. A find issues
	// one read per cycle, newest first, and compares each entry as its data returns.
	// The log RAM is not cleared; entries beyond the count are never read.
	sarl_dp #(
		.LOG_DEPTH(LOG_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// The block works on one item at a time: after an accept it is busy the next cycle.
	`SARL_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "item accepted while busy")
	// The reported count never passes the log depth.
	`SARL_ASSERT_IMP(a_count_max, m_tvalid, m_tdata[104:97] <= IDX_W'(LOG_DEPTH), "count overflow")
	// Without a hit every entry field is zero.
	`SARL_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata[96:8] == '0, "miss has data")
	// A merge always lands on an existing entry.
	`SARL_ASSERT_IMP(a_merge_cnt, m_tvalid && m_tuser[1], m_tdata[104:97] != '0, "merge on empty log")

endmodule

`default_nettype wire
